FILE: sv/wvd_pkg.sv
// ----------------------------------------------------------------------------
// wvd_pkg - vertex weld dedup shared definitions
// Default sizes, register reset value and the result layout.
// ----------------------------------------------------------------------------
`default_nettype none

package wvd_pkg;

  localparam int unsigned VERTEX_DEPTH_DEF   = 1024;
  localparam int unsigned TRIANGLE_DEPTH_DEF = 2048;
  localparam int unsigned COORD_BITS_DEF     = 24;
  localparam int unsigned RADIUS_W           = 24;
  localparam int unsigned INDEX_W            = 10;
  localparam int unsigned OUT_TDATA_W        = 40;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(16);

  typedef struct packed {
    logic               overflow;
    logic               duplicate;
    logic               new_c;
    logic               new_b;
    logic               new_a;
    logic [INDEX_W-1:0] index_c;
    logic [INDEX_W-1:0] index_b;
    logic [INDEX_W-1:0] index_a;
  } wvd_result_t;

endpackage

`default_nettype wire

FILE: sv/wvd_front.sv
// ----------------------------------------------------------------------------
// wvd_front - input side of the vertex weld dedup
// Accepts triangles and queues them in a two-entry buffer for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wvd_front import wvd_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [9*COORD_BITS-1:0] in_data,
  output logic                         q_valid,
  output logic [9*COORD_BITS-1:0]      q_data,
  input  wire logic                    q_pop
);

  logic [9*COORD_BITS-1:0] buf_r [2];
  logic                    wr_ptr_r;
  logic                    rd_ptr_r;
  logic [1:0]              cnt_r;
  logic                    push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop && q_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop && q_valid);
    end
  end

endmodule

`default_nettype wire

FILE: sv/wvd_back.sv
// ----------------------------------------------------------------------------
// wvd_back - weld and dedup engine
// Scans the vertex table once per vertex, scans the triangle table when all
// three hit, then appends and stores. Holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wvd_back import wvd_pkg::*; #(
  parameter int unsigned VERTEX_DEPTH   = VERTEX_DEPTH_DEF,
  parameter int unsigned TRIANGLE_DEPTH = TRIANGLE_DEPTH_DEF,
  parameter int unsigned COORD_BITS     = COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [RADIUS_W-1:0]     radius,
  input  wire logic                    q_valid,
  input  wire logic [9*COORD_BITS-1:0] q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output wvd_result_t                  out_res
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned VIW   = $clog2(VERTEX_DEPTH);
  localparam int unsigned TIW   = $clog2(TRIANGLE_DEPTH);
  localparam int unsigned VCW   = $clog2(VERTEX_DEPTH + 1);
  localparam int unsigned TCW   = $clog2(TRIANGLE_DEPTH + 1);
  localparam int unsigned AW    = (CB + 1 > RADIUS_W) ? CB + 1 : RADIUS_W;
  localparam int unsigned SQ_W  = 2 * RADIUS_W;
  localparam int unsigned SUM_W = SQ_W + 2;
  localparam int unsigned TRI_W = 3 * VIW;

  typedef enum logic [2:0] {
    S_IDLE, S_VSCAN, S_DECIDE, S_TSCAN, S_CHECK, S_WRITE, S_OUT
  } state_t;

  state_t                  state_r;
  logic [9*CB-1:0]         item_r;
  logic [1:0]              k_r;
  logic [VCW-1:0]          scan_i_r;
  logic [SUM_W-1:0]        best_r;
  logic                    found_r;
  logic [VIW-1:0]          best_idx_r;
  logic [2:0]              hit_r;
  logic [2:0][VIW-1:0]     idx_r;
  logic [1:0]              needed_r;
  logic [TCW-1:0]          t_i_r;
  logic                    dup_r;
  logic [VCW-1:0]          vcount_r;
  logic [TCW-1:0]          tcount_r;
  wvd_result_t             res_r;
  logic                    out_valid_r;
  wvd_result_t             out_res_r;

  logic [CB-1:0]           vx_mem [VERTEX_DEPTH];
  logic [CB-1:0]           vy_mem [VERTEX_DEPTH];
  logic [CB-1:0]           vz_mem [VERTEX_DEPTH];
  logic [TRI_W-1:0]        t_mem  [TRIANGLE_DEPTH];
  logic [CB-1:0]           rx_r, ry_r, rz_r;
  logic [TRI_W-1:0]        trd_r;

  logic                    p1_v_r, p2_v_r, p3_v_r, tv1_r;
  logic [VIW-1:0]          p1_i_r, p2_i_r, p3_i_r;
  logic                    p2_in_r, p3_in_r;
  logic [RADIUS_W-1:0]     ax_r, ay_r, az_r;
  logic [SQ_W-1:0]         sx_r, sy_r, sz_r;

  logic                    v_issue, t_issue, v_done;
  logic [CB-1:0]           qx, qy, qz;
  logic [CB:0]             dxs, dys, dzs;
  logic [CB:0]             adx, ady, adz;
  logic [AW-1:0]           ex, ey, ez, er;
  logic [SUM_W-1:0]        sum;
  logic [SQ_W-1:0]         rsq_full;
  logic [SUM_W-1:0]        rsq;
  logic [1:0]              needed;
  logic [2:0][VIW-1:0]     new_idx;
  logic [VCW-1:0]          nxt;
  logic                    t_match;
  logic                    vmem_we;
  logic [VIW-1:0]          vmem_addr;
  logic [CB-1:0]           wx, wy, wz;
  logic                    tmem_we;
  logic [TRI_W-1:0]        triple;
  wvd_result_t             res_nxt;
  wvd_result_t             res_ovf;
  logic [2:0][INDEX_W+VIW-1:0] idx_ext;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign v_issue  = (state_r == S_VSCAN) && (scan_i_r < vcount_r);
  assign v_done   = !v_issue && !p1_v_r && !p2_v_r && !p3_v_r;
  assign t_issue  = (state_r == S_TSCAN) && (t_i_r < tcount_r);
  assign triple   = {idx_r[2], idx_r[1], idx_r[0]};
  assign t_match  = tv1_r && (trd_r == triple);
  assign rsq_full = radius * radius;
  assign rsq      = SUM_W'(rsq_full);

  assign qx = item_r[(3*k_r+0)*CB +: CB];
  assign qy = item_r[(3*k_r+1)*CB +: CB];
  assign qz = item_r[(3*k_r+2)*CB +: CB];

  always_comb begin
    dxs = $signed({qx[CB-1], qx}) - $signed({rx_r[CB-1], rx_r});
    dys = $signed({qy[CB-1], qy}) - $signed({ry_r[CB-1], ry_r});
    dzs = $signed({qz[CB-1], qz}) - $signed({rz_r[CB-1], rz_r});
    adx = dxs[CB] ? -dxs : dxs;
    ady = dys[CB] ? -dys : dys;
    adz = dzs[CB] ? -dzs : dzs;
    ex  = AW'(adx);
    ey  = AW'(ady);
    ez  = AW'(adz);
    er  = AW'(radius);
    sum = SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r);
  end

  always_comb begin
    needed = 2'(!hit_r[0]) + 2'(!hit_r[1]) + 2'(!hit_r[2]);
    nxt    = vcount_r;
    for (int k = 0; k < 3; k++) begin
      new_idx[k] = idx_r[k];
      if (!hit_r[k]) begin
        new_idx[k] = nxt[VIW-1:0];
        nxt        = nxt + VCW'(1);
      end
    end
  end

  always_comb begin
    vmem_we   = (state_r == S_WRITE) && !hit_r[k_r];
    vmem_addr = idx_r[k_r];
    wx        = qx;
    wy        = qy;
    wz        = qz;
    tmem_we   = (state_r == S_WRITE) && (k_r == 2'd2) && !dup_r;
    for (int k = 0; k < 3; k++) begin
      idx_ext[k] = {INDEX_W'(0), idx_r[k]};
    end
    res_nxt           = '0;
    res_nxt.index_a   = idx_ext[0][INDEX_W-1:0];
    res_nxt.index_b   = idx_ext[1][INDEX_W-1:0];
    res_nxt.index_c   = idx_ext[2][INDEX_W-1:0];
    res_nxt.new_a     = !hit_r[0];
    res_nxt.new_b     = !hit_r[1];
    res_nxt.new_c     = !hit_r[2];
    res_nxt.duplicate = dup_r;
    res_ovf           = '0;
    res_ovf.overflow  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (vmem_we) begin
      vx_mem[vmem_addr] <= wx;
      vy_mem[vmem_addr] <= wy;
      vz_mem[vmem_addr] <= wz;
    end
    rx_r <= vx_mem[scan_i_r[VIW-1:0]];
    ry_r <= vy_mem[scan_i_r[VIW-1:0]];
    rz_r <= vz_mem[scan_i_r[VIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tmem_we) begin
      t_mem[tcount_r[TIW-1:0]] <= triple;
    end
    trd_r <= t_mem[t_i_r[TIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      tv1_r  <= 1'b0;
    end else begin
      p1_v_r <= v_issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      tv1_r  <= t_issue;
    end
    p1_i_r  <= scan_i_r[VIW-1:0];
    p2_i_r  <= p1_i_r;
    p3_i_r  <= p2_i_r;
    p2_in_r <= (ex < er) && (ey < er) && (ez < er);
    ax_r    <= ex[RADIUS_W-1:0];
    ay_r    <= ey[RADIUS_W-1:0];
    az_r    <= ez[RADIUS_W-1:0];
    p3_in_r <= p2_in_r;
    sx_r    <= ax_r * ax_r;
    sy_r    <= ay_r * ay_r;
    sz_r    <= az_r * az_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= '0;
      tcount_r    <= '0;
      out_valid_r <= 1'b0;
      k_r         <= 2'd0;
      scan_i_r    <= '0;
      t_i_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r   <= q_data;
            k_r      <= 2'd0;
            scan_i_r <= '0;
            found_r  <= 1'b0;
            best_r   <= rsq;
            state_r  <= S_VSCAN;
          end
        end
        S_VSCAN: begin
          if (v_issue) begin
            scan_i_r <= scan_i_r + VCW'(1);
          end
          if (p3_v_r && p3_in_r && (sum < best_r)) begin
            best_r     <= sum;
            best_idx_r <= p3_i_r;
            found_r    <= 1'b1;
          end
          if (v_done) begin
            hit_r[k_r] <= found_r;
            idx_r[k_r] <= found_r ? best_idx_r : '0;
            scan_i_r   <= '0;
            found_r    <= 1'b0;
            best_r     <= rsq;
            if (k_r == 2'd2) begin
              state_r <= S_DECIDE;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        S_DECIDE: begin
          needed_r <= needed;
          dup_r    <= 1'b0;
          t_i_r    <= '0;
          if ((VCW+1)'(vcount_r) + (VCW+1)'(needed) > (VCW+1)'(VERTEX_DEPTH)) begin
            res_r   <= res_ovf;
            state_r <= S_OUT;
          end else begin
            idx_r <= new_idx;
            if (needed == 2'd0 && tcount_r != '0) begin
              state_r <= S_TSCAN;
            end else begin
              state_r <= S_CHECK;
            end
          end
        end
        S_TSCAN: begin
          if (t_issue) begin
            t_i_r <= t_i_r + TCW'(1);
          end
          if (t_match) begin
            dup_r   <= 1'b1;
            state_r <= S_CHECK;
          end else if (!t_issue && !tv1_r) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          k_r <= 2'd0;
          if (!dup_r && tcount_r >= TCW'(TRIANGLE_DEPTH)) begin
            res_r   <= res_ovf;
            state_r <= S_OUT;
          end else begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (k_r == 2'd2) begin
            vcount_r <= vcount_r + VCW'(needed_r);
            tcount_r <= tcount_r + TCW'(!dup_r);
            res_r    <= res_nxt;
            state_r  <= S_OUT;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_res_r   <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= VCW'(VERTEX_DEPTH))
    else $error("vertex count beyond table depth");
  a_tri_room: assert property (@(posedge clk) disable iff (!rst_n)
    tmem_we |-> tcount_r < TCW'(TRIANGLE_DEPTH))
    else $error("triangle stored into full table");
  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.overflow |->
      !out_res_r.duplicate && !out_res_r.new_a && !out_res_r.new_b && !out_res_r.new_c)
    else $error("overflow result carries flags");
  a_dup_no_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.duplicate |->
      !out_res_r.new_a && !out_res_r.new_b && !out_res_r.new_c)
    else $error("duplicate with appended vertex");
  a_out_from_fsm: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");
`endif

endmodule

`default_nettype wire

FILE: sv/mesh_vertex_weld_dedup.sv
// ----------------------------------------------------------------------------
// mesh_vertex_weld_dedup - vertex welding with triangle dedup
// Welds the three vertices of each triangle into a vertex table and drops
// triangles whose index triple is already stored.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | in_tdata: 9 coordinates
//   out_    | out | out_tvalid/out_tready| out_tdata: indices and flags
//   cfg_    | in  | cfg_wr_en            | cfg_wr_data: match radius
//
// For each triangle, each vertex memory is read once per stored vertex for
// each of its three vertices, and the triangle memory once per stored
// triangle when all three vertices hit.
// Reset clears the counts; table contents need no clearing pass.
// A two-entry queue takes new triangles while the engine works, and the
// output register holds a result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_vertex_weld_dedup import wvd_pkg::*; #(
  parameter int unsigned VERTEX_DEPTH   = VERTEX_DEPTH_DEF,
  parameter int unsigned TRIANGLE_DEPTH = TRIANGLE_DEPTH_DEF,
  parameter int unsigned COORD_BITS     = COORD_BITS_DEF,
  localparam int unsigned IN_TDATA_W    = ((9 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero fill
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // index_a, index_b, index_c, new_a, new_b, new_c, duplicate, overflow, zero fill
  output logic [OUT_TDATA_W-1:0]     out_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [RADIUS_W-1:0]   cfg_wr_data
);

  logic [RADIUS_W-1:0]     match_radius_r;
  logic                    q_valid;
  logic                    q_pop;
  logic [9*COORD_BITS-1:0] q_data;
  wvd_result_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_radius_r <= RADIUS_RST;
    end else if (cfg_wr_en) begin
      match_radius_r <= cfg_wr_data;
    end
  end

  wvd_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_data (in_tdata[9*COORD_BITS-1:0]),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  wvd_back #(
    .VERTEX_DEPTH  (VERTEX_DEPTH),
    .TRIANGLE_DEPTH(TRIANGLE_DEPTH),
    .COORD_BITS    (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .radius   (match_radius_r),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = OUT_TDATA_W'(res);

endmodule

`default_nettype wire
